// ----- rtl/core/htlp_pkg.sv -----
// ----------------------------------------------------------------------------
// htlp_pkg: shared types and tables for the HTTP token list parser
// Beat structs, parser phases, octet classes, and the step table.
// ----------------------------------------------------------------------------
package htlp_pkg;

    // Input beat: one octet of the field value, or the end marker
    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_end;
    } in_item_t;

    // Result beat: one per input beat
    typedef struct packed {
        logic       char_valid;
        logic [7:0] char_out;
        logic       token_end;
        logic       field_done;
        logic       matched;
        logic       parse_error;
    } out_item_t;

    // Parser phases
    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_FIRST = 3'd1,
        PH_TOKEN = 3'd2,
        PH_AFTER = 3'd3,
        PH_COMMA = 3'd4,
        PH_FAIL  = 3'd5
    } phase_t;

    // Octet classes; end marker gets its own class
    typedef enum logic [2:0] {
        CLS_INVALID = 3'd0,
        CLS_TCHAR   = 3'd1,
        CLS_COMMA   = 3'd2,
        CLS_SPACE   = 3'd3,
        CLS_END     = 3'd4
    } cls_t;

    // Action taken on a transition
    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_EMIT  = 2'd1,
        ACT_CLOSE = 2'd2
    } act_t;

    // One step table entry
    typedef struct packed {
        logic   ok;
        act_t   act;
        phase_t nxt;
    } step_t;

    // Registered input beat with its class
    typedef struct packed {
        logic       valid;
        logic [7:0] data_byte;
        logic       is_end;
        cls_t       cls;
    } stage_t;

    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET   = 8'h20;

    // 4-bit class per octet 0..127, eight octets per word, first octet in
    // the top nibble
    localparam logic [31:0] OCTET_CLASS_TABLE [16] = '{
        32'h00000000, 32'h03000000, 32'h00000000, 32'h00000000,
        32'h31011111, 32'h00112110, 32'h11111111, 32'h11000000,
        32'h01111111, 32'h11111111, 32'h11111111, 32'h11100011,
        32'h11111111, 32'h11111111, 32'h11111111, 32'h11101010
    };

    // Class of a raw octet; anything 128 and up is invalid
    function automatic cls_t octet_class(input logic [7:0] b);
        logic [31:0] word;
        logic [4:0]  sh;
        logic [31:0] shifted;
        cls_t        c;
        word    = OCTET_CLASS_TABLE[b[6:3]];
        sh      = {3'd7 - b[2:0], 2'b00};
        shifted = word >> sh;
        if (b[7])
            c = CLS_INVALID;
        else
            c = cls_t'(shifted[2:0]);
        return c;
    endfunction

    // Transition table for a resolved phase (never START)
    function automatic step_t step_lookup(input phase_t p, input cls_t c);
        step_t s;
        s = '{ok: 1'b0, act: ACT_NONE, nxt: PH_FAIL};
        unique case (p)
            PH_FIRST:
                unique case (c)
                    CLS_TCHAR: s = '{ok: 1'b1, act: ACT_EMIT, nxt: PH_TOKEN};
                    CLS_COMMA: s = '{ok: 1'b1, act: ACT_NONE, nxt: PH_FIRST};
                    CLS_SPACE: s = '{ok: 1'b1, act: ACT_NONE, nxt: PH_FIRST};
                    default:   s = '{ok: 1'b0, act: ACT_NONE, nxt: PH_FAIL};
                endcase
            PH_TOKEN:
                unique case (c)
                    CLS_TCHAR: s = '{ok: 1'b1, act: ACT_EMIT,  nxt: PH_TOKEN};
                    CLS_COMMA: s = '{ok: 1'b1, act: ACT_CLOSE, nxt: PH_COMMA};
                    CLS_SPACE: s = '{ok: 1'b1, act: ACT_CLOSE, nxt: PH_AFTER};
                    CLS_END:   s = '{ok: 1'b1, act: ACT_CLOSE, nxt: PH_START};
                    default:   s = '{ok: 1'b0, act: ACT_NONE,  nxt: PH_FAIL};
                endcase
            PH_AFTER:
                unique case (c)
                    CLS_COMMA: s = '{ok: 1'b1, act: ACT_NONE, nxt: PH_COMMA};
                    CLS_SPACE: s = '{ok: 1'b1, act: ACT_NONE, nxt: PH_AFTER};
                    CLS_END:   s = '{ok: 1'b1, act: ACT_NONE, nxt: PH_START};
                    default:   s = '{ok: 1'b0, act: ACT_NONE, nxt: PH_FAIL};
                endcase
            PH_COMMA:
                unique case (c)
                    CLS_TCHAR: s = '{ok: 1'b1, act: ACT_EMIT, nxt: PH_TOKEN};
                    CLS_COMMA: s = '{ok: 1'b1, act: ACT_NONE, nxt: PH_COMMA};
                    CLS_SPACE: s = '{ok: 1'b1, act: ACT_NONE, nxt: PH_COMMA};
                    CLS_END:   s = '{ok: 1'b1, act: ACT_NONE, nxt: PH_START};
                    default:   s = '{ok: 1'b0, act: ACT_NONE, nxt: PH_FAIL};
                endcase
            default:
                s = '{ok: 1'b0, act: ACT_NONE, nxt: PH_FAIL};
        endcase
        return s;
    endfunction

    // ASCII lower case
    function automatic logic [7:0] to_lower(input logic [7:0] b);
        logic [7:0] r;
        if (b >= ASCII_UPPER_A && b <= ASCII_UPPER_Z)
            r = b + CASE_OFFSET;
        else
            r = b;
        return r;
    endfunction

endpackage

// ----- rtl/core/htlp_in_stage.sv -----
// ----------------------------------------------------------------------------
// htlp_in_stage: input register
// Captures one input beat, classifies the octet on the way in, and holds it
// while the parser stage is stalled.
// ----------------------------------------------------------------------------
module htlp_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  htlp_pkg::in_item_t in_data,
    input  logic              advance,
    output htlp_pkg::stage_t  stage
);
    import htlp_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       end_reg;
    cls_t       cls_reg;
    logic       load;

    // Register is free when empty or when its beat moves on this cycle
    assign in_stall = valid_reg && !advance;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload, class computed before the register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= in_data.data_byte;
            end_reg  <= in_data.is_end;
            cls_reg  <= in_data.is_end ? CLS_END : octet_class(in_data.data_byte);
        end
    end

    assign stage = '{valid: valid_reg, data_byte: byte_reg, is_end: end_reg,
                     cls: cls_reg};

endmodule

// ----- rtl/core/htlp_fsm.sv -----
// ----------------------------------------------------------------------------
// htlp_fsm: token list automaton
// Holds the parse phase and forms the result beat for the registered input.
// ----------------------------------------------------------------------------
module htlp_fsm (
    input  logic                clk,
    input  logic                rst_n,
    input  htlp_pkg::stage_t    stage,
    input  logic                step,
    input  logic                require_one_token,
    output htlp_pkg::out_item_t result
);
    import htlp_pkg::*;

    phase_t phase_reg;
    phase_t phase_next;
    phase_t eff_phase;
    step_t  tr;

    // Start phase resolves from the config bit
    always_comb
    begin
        if (phase_reg == PH_START)
            eff_phase = require_one_token ? PH_FIRST : PH_COMMA;
        else
            eff_phase = phase_reg;
        tr = step_lookup(eff_phase, stage.cls);
    end

    // Next state
    always_comb
    begin
        phase_next = phase_reg;
        if (step)
        begin
            if (stage.is_end)
                phase_next = PH_START;
            else if (eff_phase == PH_FAIL)
                phase_next = PH_FAIL;
            else if (!tr.ok)
                phase_next = PH_FAIL;
            else
                phase_next = tr.nxt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= PH_START;
        else
            phase_reg <= phase_next;
    end

    // Outputs
    always_comb
    begin
        result = '0;
        if (stage.is_end)
        begin
            result.field_done = 1'b1;
            if (eff_phase != PH_FAIL)
            begin
                if (tr.ok)
                begin
                    result.matched   = 1'b1;
                    result.token_end = (tr.act == ACT_CLOSE);
                end
                else
                begin
                    result.parse_error = 1'b1;
                end
            end
        end
        else if (eff_phase != PH_FAIL)
        begin
            if (!tr.ok)
                result.parse_error = 1'b1;
            else
            begin
                unique case (tr.act)
                    ACT_EMIT:
                    begin
                        result.char_valid = 1'b1;
                        result.char_out   = to_lower(stage.data_byte);
                    end
                    ACT_CLOSE: result.token_end = 1'b1;
                    ACT_NONE:  result = '0;
                    default:   result = '0;
                endcase
            end
        end
    end

    // Checks
    a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        step && stage.is_end |=> phase_reg == PH_START)
        else $error("phase not back to start after end marker");

    a_fail_silent: assert property (@(posedge clk) disable iff (!rst_n)
        step && !stage.is_end && phase_reg == PH_FAIL |-> result == '0)
        else $error("output after failure");

    a_error_enters_fail: assert property (@(posedge clk) disable iff (!rst_n)
        step && !stage.is_end && result.parse_error |=> phase_reg == PH_FAIL)
        else $error("error without failed phase");

    a_match_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        result.matched |-> result.field_done && !result.parse_error)
        else $error("match outside end marker");

endmodule

// ----- rtl/core/http_token_list_parser_unit.sv -----
// ----------------------------------------------------------------------------
// http_token_list_parser_unit: HTTP comma-separated token list parser
// Takes one octet of a header field value per beat, or an end marker, and
// returns one result beat per input beat: a lowercased token character, a
// token end flag, or on the end marker whether the list matched. The parser
// accepts one beat every clock cycle unless held by in_stall; each beat passes
// an input register and then a result register, from which its result is
// offered and leaves when the output is not stalled. The loop through the
// parse phase register sets that rate. An error flags the first bad octet;
// later octets give empty results until the end marker restarts the parser.
// The config bit require_one_token (reset 1) makes an empty list fail; write
// it only while the parser is idle. On a failed field the consumer drops the
// tokens it got.
// ----------------------------------------------------------------------------
module http_token_list_parser_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  htlp_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output htlp_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data
);
    import htlp_pkg::*;

    stage_t    stage;
    out_item_t result;
    logic      advance;
    logic      step;
    logic      req_reg;
    logic      out_valid_reg;
    out_item_t out_data_reg;

    // Result register can take a beat when empty or draining
    assign advance = !out_valid_reg || !out_stall;
    assign step    = stage.valid && advance;

    htlp_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .advance  (advance),
        .stage    (stage)
    );

    htlp_fsm u_fsm (
        .clk               (clk),
        .rst_n             (rst_n),
        .stage             (stage),
        .step              (step),
        .require_one_token (req_reg),
        .result            (result)
    );

    // Config register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_reg <= 1'b1;
        else if (cfg_valid && cfg_ready)
            req_reg <= cfg_data;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= stage.valid;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            out_data_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for http_token_list_parser_unit
// Feeds header field values one octet per beat, closed by an end marker, and
// predicts every result beat from an independent model of the token list
// automaton. Covers directed edge cases, then random fields (mostly well
// formed lists, some corrupted or pure noise) under four idle/stall mixes,
// switching require_one_token between phases.
// ----------------------------------------------------------------------------
module testbench;
    import htlp_pkg::*;

    // Expected-result store plus its own copy of the parser state
    class token_scoreboard;
        out_item_t expected_q[$];
        phase_t    phase;
        bit        require_one;
        int        fail_count;

        function new();
            phase       = PH_START;
            require_one = 1'b1;
            fail_count  = 0;
        endfunction

        // Octet class: tab/space, comma, RFC tchar, or invalid
        static function cls_t classify(logic [7:0] b);
            cls_t c;
            c = CLS_INVALID;
            if (b == 8'h09 || b == 8'h20)
                c = CLS_SPACE;
            else if (b == 8'h2C)
                c = CLS_COMMA;
            else if ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
                     (b >= 8'h61 && b <= 8'h7A))
                c = CLS_TCHAR;
            else
                case (b)
                    // ! # $ % & ' * + - . ^ _ ` | ~
                    8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
                    8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E:
                        c = CLS_TCHAR;
                    default:
                        c = CLS_INVALID;
                endcase
            return c;
        endfunction

        // Predict the result of one accepted beat; returns 0 if the beat
        // is merely skipped (octet after a failure)
        function bit note_beat(in_item_t b);
            out_item_t r;
            phase_t    p;
            bit        live;
            r    = '0;
            p    = (phase == PH_START) ? (require_one ? PH_FIRST : PH_COMMA) : phase;
            live = b.is_end || (p != PH_FAIL);
            if (b.is_end)
            begin
                r.field_done = 1'b1;
                if (p == PH_FIRST)
                    r.parse_error = 1'b1;
                else if (p != PH_FAIL)
                begin
                    r.matched   = 1'b1;
                    r.token_end = (p == PH_TOKEN);
                end
                phase = PH_START;
            end
            else if (p != PH_FAIL)
            begin
                phase = p;
                case (classify(b.data_byte))
                    CLS_TCHAR:
                        if (p == PH_AFTER)
                        begin
                            r.parse_error = 1'b1;
                            phase         = PH_FAIL;
                        end
                        else
                        begin
                            r.char_valid = 1'b1;
                            r.char_out   = (b.data_byte >= 8'h41 && b.data_byte <= 8'h5A) ?
                                           b.data_byte + 8'h20 : b.data_byte;
                            phase        = PH_TOKEN;
                        end
                    CLS_COMMA:
                    begin
                        r.token_end = (p == PH_TOKEN);
                        phase       = (p == PH_FIRST) ? PH_FIRST : PH_COMMA;
                    end
                    CLS_SPACE:
                    begin
                        r.token_end = (p == PH_TOKEN);
                        phase       = (p == PH_TOKEN) ? PH_AFTER : p;
                    end
                    default:
                    begin
                        r.parse_error = 1'b1;
                        phase         = PH_FAIL;
                    end
                endcase
            end
            expected_q.insert(expected_q.size(), r);
            return live;
        endfunction

        function void compare_field(string name, int unsigned exp, int unsigned act);
            if (exp != act)
            begin
                $error("%s: expected %0h, actual %0h", name, exp, act);
                fail_count++;
            end
        endfunction

        // Compare one accepted result beat against the oldest expectation
        function void check_beat(out_item_t got);
            out_item_t exp;
            if (expected_q.size() == 0)
            begin
                $error("result beat with nothing expected: %h", got);
                fail_count++;
            end
            else
            begin
                exp = expected_q.pop_front();
                compare_field("char_valid", exp.char_valid, got.char_valid);
                compare_field("char_out", exp.char_out, got.char_out);
                compare_field("token_end", exp.token_end, got.token_end);
                compare_field("field_done", exp.field_done, got.field_done);
                compare_field("matched", exp.matched, got.matched);
                compare_field("parse_error", exp.parse_error, got.parse_error);
            end
        endfunction
    endclass

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    in_item_t   in_data   = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    out_item_t  out_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_data  = 1'b0;

    token_scoreboard sb = new();
    in_item_t        field_q[$];
    int              send_idle_pct  = 0;
    int              recv_stall_pct = 0;
    int              live_beats     = 0;

    http_token_list_parser_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side: check accepted beats, then pick the next stall
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_beat(out_data);
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Drive one input beat, with random idle cycles ahead of it
    task automatic send_beat(input in_item_t b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (sb.note_beat(b))
            live_beats++;
    endtask

    // Send whatever sits in field_q, then empty the queue
    task automatic send_field();
        foreach (field_q[i])
            send_beat(field_q[i]);
        field_q.delete();
    endtask

    task automatic push_octet(input logic [7:0] b);
        in_item_t it;
        it = '{data_byte: b, is_end: 1'b0};
        field_q.insert(field_q.size(), it);
    endtask

    task automatic push_end();
        in_item_t it;
        it = '{data_byte: 8'($urandom_range(255)), is_end: 1'b1};
        field_q.insert(field_q.size(), it);
    endtask

    task automatic push_tchar();
        logic [7:0] b;
        b = 8'($urandom_range(33, 126));
        while (token_scoreboard::classify(b) != CLS_TCHAR)
            b = 8'($urandom_range(33, 126));
        push_octet(b);
    endtask

    task automatic push_ws(input int unsigned max_n);
        repeat ($urandom_range(max_n))
            push_octet($urandom_range(1) ? 8'h20 : 8'h09);
    endtask

    // Random field: mostly well-formed lists, some corrupted, some noise
    task automatic build_field();
        int unsigned mode;
        int unsigned ntok;
        int unsigned pos;
        mode = $urandom_range(99);
        if (mode < 10)
        begin
            repeat ($urandom_range(1, 8))
                push_octet(8'($urandom_range(255)));
        end
        else
        begin
            repeat ($urandom_range(2))
                push_octet($urandom_range(2) == 0 ? 8'h2C : 8'h20);
            ntok = $urandom_range(4);
            for (int i = 0; i < ntok; i++)
            begin
                if (i > 0)
                begin
                    push_ws(1);
                    push_octet(8'h2C);
                    push_ws(2);
                end
                repeat ($urandom_range(1, 5))
                    push_tchar();
            end
            push_ws(1);
            if ($urandom_range(5) == 0)
                push_octet(8'h2C);
            // corrupt one octet now and then
            if (mode < 25 && field_q.size() > 0)
            begin
                pos = $urandom_range(field_q.size() - 1);
                field_q[pos].data_byte = 8'($urandom_range(255));
            end
        end
        push_end();
        send_field();
    endtask

    // Write require_one_token; caller keeps the parser idle
    task automatic write_require_token(input logic v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.require_one = v;
    endtask

    // Stop driving and wait until every expected result has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
    endtask

    // Main sequence
    initial
    begin
        int target;
        int fails;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, require_one_token at its reset value
        push_end();                                     // empty list fails
        push_octet(8'h09); push_octet(8'h2C);           // leading tab, comma
        push_octet("A");   push_octet("Z"); push_octet(8'h7E);
        push_octet(8'h20); push_octet(8'h2C); push_octet(8'h20);
        push_octet(8'h21); push_end();                  // ends inside a token
        push_octet("a");   push_octet(8'h2C); push_end(); // trailing comma
        push_octet("x");   push_octet(8'h20);
        push_octet("y");   push_octet("B");   push_end(); // token after space
        push_octet(8'h00); push_end();                  // octet zero invalid
        push_octet("q");   push_octet(8'hFF); push_end(); // high octet
        send_field();
        drain();

        // Directed, empty lists allowed
        write_require_token(1'b0);
        push_end();
        push_octet(8'h20); push_end();
        push_octet(8'h2C); push_end();
        send_field();
        drain();

        // Random phases: idle/stall mix and register value per phase
        target = live_beats;
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            write_require_token(ph[0] ? 1'b0 : 1'b1);
            target += 310;
            while (live_beats < target)
                build_field();
            drain();
        end

        repeat (4) @(posedge clk);
        fails = sb.fail_count;
        if (sb.expected_q.size() != 0)
        begin
            $error("%0d expected results never arrived", sb.expected_q.size());
            fails++;
        end
        if (fails == 0)
            $display("http_token_list_parser_unit verification clean");
        else
            $display("http_token_list_parser_unit verification failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("http_token_list_parser_unit verification failed");
        $finish;
    end

endmodule
